// ===== sv/assert_macros.svh =====
// Assertion macros shared by the handler RTL.
// Needs nothing else; files that assert pull this header in by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/usbreq_pkg.sv =====
// Package for the USB standard request handler: codes, sizes and the
// structs passed between its modules. Depends on nothing.
`timescale 1ns / 1ps

package usbreq_pkg;

    localparam int unsigned MAX_CONFIGURATIONS = 1;
    localparam int unsigned MAX_INTERFACES     = 2;
    localparam int unsigned ENDPOINT_COUNT     = 4;

    // OUT endpoints sit in the low half of the halt vector, IN endpoints above.
    localparam int unsigned HALT_SLOTS = 2 * ENDPOINT_COUNT;
    localparam int unsigned HALT_IDX_W = (HALT_SLOTS > 1) ? $clog2(HALT_SLOTS) : 1;

    // Device states.
    localparam logic [1:0] ST_DEFAULT    = 2'd0;
    localparam logic [1:0] ST_ADDRESSED  = 2'd1;
    localparam logic [1:0] ST_CONFIGURED = 2'd2;

    // Reply actions.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_ZLP   = 3'd1;
    localparam logic [2:0] ACT_DATA  = 3'd2;
    localparam logic [2:0] ACT_STALL = 3'd3;
    localparam logic [2:0] ACT_DESC  = 3'd4;
    localparam logic [2:0] ACT_CLASS = 3'd5;

    // Descriptor selects.
    localparam logic [2:0] SEL_DEVICE       = 3'd0;
    localparam logic [2:0] SEL_CONFIG       = 3'd1;
    localparam logic [2:0] SEL_LANGID       = 3'd2;
    localparam logic [2:0] SEL_MANUFACTURER = 3'd3;
    localparam logic [2:0] SEL_PRODUCT      = 3'd4;
    localparam logic [2:0] SEL_QUALIFIER    = 3'd5;

    // Recipients, bmRequestType bits 4:0.
    localparam logic [4:0] RCPT_DEVICE    = 5'd0;
    localparam logic [4:0] RCPT_INTERFACE = 5'd1;
    localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

    // Request type field, bmRequestType bits 6:5.
    localparam logic [1:0] TYPE_CLASS = 2'd1;

    // Standard request codes.
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    // Feature selectors.
    localparam logic [15:0] FEAT_ENDPOINT_HALT = 16'd0;
    localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;

    // Descriptor types, wValue high byte.
    localparam logic [7:0] DT_DEVICE    = 8'd1;
    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_STRING    = 8'd3;
    localparam logic [7:0] DT_QUALIFIER = 8'd6;

    // String indexes, wValue low byte.
    localparam logic [7:0] STR_LANGID       = 8'd0;
    localparam logic [7:0] STR_MANUFACTURER = 8'd1;
    localparam logic [7:0] STR_PRODUCT      = 8'd2;
    localparam logic [7:0] STR_SERIAL       = 8'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_LEN       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_LEN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LANGID_LEN       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUFACTURER_LEN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRODUCT_LEN      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUALIFIER_LEN    = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_req;

    typedef struct packed {
        logic [7:0] device_len;
        logic [9:0] config_len;
        logic [7:0] langid_len;
        logic [7:0] manufacturer_len;
        logic [7:0] product_len;
        logic [7:0] qualifier_len;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            dev_state;
        logic [7:0]            active_config;
        logic                  remote_wakeup;
        logic [HALT_SLOTS-1:0] halt;
    } t_dev;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] reply_data;
        logic [15:0] reply_length;
        logic [2:0]  descriptor_select;
        logic        address_load;
        logic [6:0]  new_address;
        logic        config_load;
        logic [7:0]  config_number;
        logic        is_configured;
    } t_result;

endpackage

// ===== sv/usbreq_cfg.sv =====
// Descriptor length registers written through the plain write port.
// Depends on usbreq_pkg.
`timescale 1ns / 1ps

module usbreq_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [usbreq_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [usbreq_pkg::CFG_DATA_W-1:0]  i_data,
    output usbreq_pkg::t_cfg                   o_cfg
);

    usbreq_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_len       <= 8'd18;
            r_cfg.config_len       <= 10'd67;
            r_cfg.langid_len       <= 8'd4;
            r_cfg.manufacturer_len <= 8'd2;
            r_cfg.product_len      <= 8'd2;
            r_cfg.qualifier_len    <= 8'd10;
        end else if (i_we) begin
            case (i_index)
                usbreq_pkg::CFG_DEVICE_LEN:       r_cfg.device_len       <= i_data[7:0];
                usbreq_pkg::CFG_CONFIG_LEN:       r_cfg.config_len       <= i_data[9:0];
                usbreq_pkg::CFG_LANGID_LEN:       r_cfg.langid_len       <= i_data[7:0];
                usbreq_pkg::CFG_MANUFACTURER_LEN: r_cfg.manufacturer_len <= i_data[7:0];
                usbreq_pkg::CFG_PRODUCT_LEN:      r_cfg.product_len      <= i_data[7:0];
                usbreq_pkg::CFG_QUALIFIER_LEN:    r_cfg.qualifier_len    <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/usbreq_state.sv =====
// Device state registers: state, active configuration, remote wakeup and
// endpoint halt bits. Depends on usbreq_pkg.
`timescale 1ns / 1ps

module usbreq_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_update,
    input  usbreq_pkg::t_dev i_next,
    output usbreq_pkg::t_dev o_dev
);

    usbreq_pkg::t_dev r_dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev.dev_state     <= usbreq_pkg::ST_DEFAULT;
            r_dev.active_config <= 8'd0;
            r_dev.remote_wakeup <= 1'b0;
            r_dev.halt          <= '0;
        end else if (i_update) begin
            r_dev <= i_next;
        end
    end

    assign o_dev = r_dev;

endmodule

// ===== sv/usbreq_decode.sv =====
// Combinational request decoder: one setup word or bus reset in, one reply
// and the next device state out. Depends on usbreq_pkg.
`timescale 1ns / 1ps

module usbreq_decode (
    input  usbreq_pkg::t_req    i_req,
    input  usbreq_pkg::t_dev    i_dev,
    input  usbreq_pkg::t_cfg    i_cfg,
    output usbreq_pkg::t_result o_res,
    output usbreq_pkg::t_dev    o_dev_next
);

    logic [1:0]                       st;
    logic [7:0]                       code;
    logic [15:0]                      value;
    logic [15:0]                      length;
    logic [7:0]                       ep;
    logic                             ep0;
    logic                             slot_ok;
    logic [usbreq_pkg::HALT_IDX_W-1:0] slot;
    logic                             halt_rd;
    logic                             halt_we;
    logic                             halt_val;
    logic                             desc_hit;
    logic [9:0]                       desc_n;
    logic [2:0]                       desc_sel;
    logic [15:0]                      desc_n16;
    logic [7:0]                       cfg_val;

    // The unused state code behaves as the default state.
    assign st     = (i_dev.dev_state == usbreq_pkg::ST_CONFIGURED ||
                     i_dev.dev_state == usbreq_pkg::ST_ADDRESSED) ?
                    i_dev.dev_state : usbreq_pkg::ST_DEFAULT;
    assign code   = i_req.request_code;
    assign value  = i_req.request_value;
    assign length = i_req.request_length;
    assign cfg_val = value[7:0];

    // Endpoint slot: endpoints beyond the implemented count have no halt bit.
    assign ep      = i_req.request_index[7:0];
    assign ep0     = (ep[6:0] == 7'd0);
    assign slot_ok = 32'(ep[3:0]) < usbreq_pkg::ENDPOINT_COUNT;
    assign slot    = usbreq_pkg::HALT_IDX_W'(ep[7] ?
                     usbreq_pkg::ENDPOINT_COUNT + 32'(ep[3:0]) : 32'(ep[3:0]));
    assign halt_rd = slot_ok && i_dev.halt[slot];

    always_comb begin
        desc_hit = 1'b1;
        desc_n   = 10'd0;
        desc_sel = usbreq_pkg::SEL_DEVICE;
        case (value[15:8])
            usbreq_pkg::DT_DEVICE: begin
                desc_n   = {2'b00, i_cfg.device_len};
                desc_sel = usbreq_pkg::SEL_DEVICE;
            end
            usbreq_pkg::DT_CONFIG: begin
                desc_n   = i_cfg.config_len;
                desc_sel = usbreq_pkg::SEL_CONFIG;
            end
            usbreq_pkg::DT_STRING: begin
                case (value[7:0]) inside
                    usbreq_pkg::STR_LANGID: begin
                        desc_n   = {2'b00, i_cfg.langid_len};
                        desc_sel = usbreq_pkg::SEL_LANGID;
                    end
                    usbreq_pkg::STR_MANUFACTURER: begin
                        desc_n   = {2'b00, i_cfg.manufacturer_len};
                        desc_sel = usbreq_pkg::SEL_MANUFACTURER;
                    end
                    // The serial number string shares the product length.
                    usbreq_pkg::STR_PRODUCT, usbreq_pkg::STR_SERIAL: begin
                        desc_n   = {2'b00, i_cfg.product_len};
                        desc_sel = usbreq_pkg::SEL_PRODUCT;
                    end
                    default: desc_hit = 1'b0;
                endcase
            end
            usbreq_pkg::DT_QUALIFIER: begin
                desc_n   = {2'b00, i_cfg.qualifier_len};
                desc_sel = usbreq_pkg::SEL_QUALIFIER;
            end
            default: desc_hit = 1'b0;
        endcase
    end

    assign desc_n16 = {6'd0, desc_n};

    always_comb begin
        o_res      = '0;
        o_dev_next = i_dev;
        halt_we    = 1'b0;
        halt_val   = 1'b0;

        if (i_req.mode) begin
            o_dev_next.dev_state = usbreq_pkg::ST_DEFAULT;
        end else begin
            case (i_req.request_type[4:0])
                usbreq_pkg::RCPT_DEVICE: begin
                    case (code)
                        usbreq_pkg::REQ_GET_STATUS: begin
                            if (st == usbreq_pkg::ST_DEFAULT) begin
                                o_res.action = usbreq_pkg::ACT_STALL;
                            end else begin
                                o_res.action       = usbreq_pkg::ACT_DATA;
                                o_res.reply_data   = {14'd0, i_dev.remote_wakeup, 1'b1};
                                o_res.reply_length = 16'd2;
                            end
                        end
                        usbreq_pkg::REQ_CLEAR_FEATURE: begin
                            if (st == usbreq_pkg::ST_DEFAULT) begin
                                o_res.action = usbreq_pkg::ACT_STALL;
                            end else if (value == usbreq_pkg::FEAT_REMOTE_WAKEUP) begin
                                o_dev_next.remote_wakeup = 1'b0;
                                o_res.action             = usbreq_pkg::ACT_ZLP;
                            end
                        end
                        usbreq_pkg::REQ_SET_FEATURE: begin
                            if (value == usbreq_pkg::FEAT_REMOTE_WAKEUP) begin
                                o_dev_next.remote_wakeup = 1'b1;
                                o_res.action             = usbreq_pkg::ACT_ZLP;
                            end
                        end
                        usbreq_pkg::REQ_SET_ADDRESS: begin
                            if (i_req.request_index != 16'd0 || length != 16'd0 ||
                                st == usbreq_pkg::ST_CONFIGURED) begin
                                o_res.action = usbreq_pkg::ACT_STALL;
                            end else begin
                                o_res.address_load   = 1'b1;
                                o_res.new_address    = value[6:0];
                                o_res.action         = usbreq_pkg::ACT_ZLP;
                                o_dev_next.dev_state = (value[6:0] != 7'd0) ?
                                    usbreq_pkg::ST_ADDRESSED : usbreq_pkg::ST_DEFAULT;
                            end
                        end
                        usbreq_pkg::REQ_GET_DESCRIPTOR: begin
                            if (desc_hit) begin
                                o_res.action            = usbreq_pkg::ACT_DESC;
                                o_res.descriptor_select = desc_sel;
                                o_res.reply_length      = (desc_n16 < length) ?
                                                          desc_n16 : length;
                            end else begin
                                o_res.action = usbreq_pkg::ACT_STALL;
                            end
                        end
                        usbreq_pkg::REQ_GET_CONFIG: begin
                            if (length != 16'd1 || st == usbreq_pkg::ST_DEFAULT) begin
                                o_res.action = usbreq_pkg::ACT_STALL;
                            end else begin
                                o_res.action       = usbreq_pkg::ACT_DATA;
                                o_res.reply_data   = (st == usbreq_pkg::ST_CONFIGURED) ?
                                                     {8'd0, i_dev.active_config} : 16'd0;
                                o_res.reply_length = 16'd1;
                            end
                        end
                        usbreq_pkg::REQ_SET_CONFIG: begin
                            if (32'(cfg_val) > usbreq_pkg::MAX_CONFIGURATIONS ||
                                st == usbreq_pkg::ST_DEFAULT) begin
                                o_res.action = usbreq_pkg::ACT_STALL;
                            end else begin
                                o_res.action = usbreq_pkg::ACT_ZLP;
                                if (st == usbreq_pkg::ST_ADDRESSED) begin
                                    if (cfg_val != 8'd0) begin
                                        o_dev_next.active_config = cfg_val;
                                        o_dev_next.dev_state     = usbreq_pkg::ST_CONFIGURED;
                                        o_res.config_load        = 1'b1;
                                        o_res.config_number      = cfg_val;
                                    end
                                end else begin
                                    o_dev_next.active_config = cfg_val;
                                    if (cfg_val == 8'd0) begin
                                        o_dev_next.dev_state = usbreq_pkg::ST_ADDRESSED;
                                    end
                                end
                            end
                        end
                        default: o_res.action = usbreq_pkg::ACT_STALL;
                    endcase
                end

                usbreq_pkg::RCPT_INTERFACE: begin
                    if (st != usbreq_pkg::ST_CONFIGURED ||
                        32'(i_req.request_index[7:0]) > usbreq_pkg::MAX_INTERFACES) begin
                        o_res.action = usbreq_pkg::ACT_STALL;
                    end else if (i_req.request_type[6:5] == usbreq_pkg::TYPE_CLASS) begin
                        o_res.action = usbreq_pkg::ACT_CLASS;
                    end else if (length == 16'd0) begin
                        o_res.action = usbreq_pkg::ACT_ZLP;
                    end
                end

                usbreq_pkg::RCPT_ENDPOINT: begin
                    if (st == usbreq_pkg::ST_DEFAULT ||
                        !(code == usbreq_pkg::REQ_GET_STATUS ||
                          code == usbreq_pkg::REQ_CLEAR_FEATURE ||
                          code == usbreq_pkg::REQ_SET_FEATURE)) begin
                        o_res.action = usbreq_pkg::ACT_STALL;
                    end else if (code == usbreq_pkg::REQ_GET_STATUS) begin
                        if (st == usbreq_pkg::ST_ADDRESSED && !ep0) begin
                            o_res.action = usbreq_pkg::ACT_STALL;
                        end else begin
                            // EP0 always reports not halted.
                            o_res.action       = usbreq_pkg::ACT_DATA;
                            o_res.reply_data   = {15'd0,
                                (st == usbreq_pkg::ST_CONFIGURED) && !ep0 && halt_rd};
                            o_res.reply_length = 16'd2;
                        end
                    end else if (st == usbreq_pkg::ST_ADDRESSED) begin
                        // Feature requests while only addressed halt the endpoint
                        // and still stall the control pipe.
                        halt_we      = !ep0;
                        halt_val     = 1'b1;
                        o_res.action = usbreq_pkg::ACT_STALL;
                    end else if (code == usbreq_pkg::REQ_CLEAR_FEATURE) begin
                        if (value == usbreq_pkg::FEAT_ENDPOINT_HALT) begin
                            halt_we      = !ep0;
                            halt_val     = 1'b0;
                            o_res.action = usbreq_pkg::ACT_ZLP;
                        end
                    end else begin
                        halt_we      = (value == usbreq_pkg::FEAT_ENDPOINT_HALT) &&
                                       !ep0 && (length == 16'd0);
                        halt_val     = 1'b1;
                        o_res.action = usbreq_pkg::ACT_ZLP;
                    end
                end

                default: o_res.action = usbreq_pkg::ACT_STALL;
            endcase
        end

        if (halt_we && slot_ok) begin
            o_dev_next.halt[slot] = halt_val;
        end
        o_res.is_configured = (o_dev_next.dev_state == usbreq_pkg::ST_CONFIGURED);
    end

endmodule

// ===== sv/usb_standard_request_handler_top.sv =====
// USB standard request handler, top level: input word register, decoder,
// state and length registers, result register.
// Depends on usbreq_pkg, usbreq_cfg, usbreq_state, usbreq_decode, assert_macros.svh.
//
// Usage:
//   Input channel: i_valid / o_stall with one setup packet or bus reset event
//   per word (i_mode high for a bus reset). Output channel: o_valid / i_stall
//   with one reply word per input word, in order.
//   A word is taken into the input register when i_valid is high and o_stall
//   low. There it is decoded against the current device state; when the result
//   register frees up, the state is updated and the reply loaded into it.
//   Throughput is one word per cycle while the receiver does not stall; the
//   shared state update is the only dependency between words and completes
//   within the decode cycle. When the receiver stalls, the result register
//   holds its word and the input register holds one more; o_stall rises only
//   while both are full. The user must write the descriptor lengths on the
//   i_cfg_we port only while no word is in flight; the block does not enforce
//   this. Synchronous reset clears both registers, returns the device to the
//   default state with no configuration, remote wakeup off and all endpoint
//   halts cleared, and restores the default descriptor lengths.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usb_standard_request_handler_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_we,
    input  logic [usbreq_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [usbreq_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic [7:0]                         i_request_type,
    input  logic [7:0]                         i_request_code,
    input  logic [15:0]                        i_request_value,
    input  logic [15:0]                        i_request_index,
    input  logic [15:0]                        i_request_length,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_action,
    output logic [15:0]                        o_reply_data,
    output logic [15:0]                        o_reply_length,
    output logic [2:0]                         o_descriptor_select,
    output logic                               o_address_load,
    output logic [6:0]                         o_new_address,
    output logic                               o_config_load,
    output logic [7:0]                         o_config_number,
    output logic                               o_is_configured
);

    usbreq_pkg::t_req    w_req;
    usbreq_pkg::t_req    r_req;
    usbreq_pkg::t_cfg    w_cfg;
    usbreq_pkg::t_dev    w_dev;
    usbreq_pkg::t_dev    w_dev_next;
    usbreq_pkg::t_result w_res;
    usbreq_pkg::t_result r_res;

    logic r_in_valid;
    logic n_in_valid;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_ready;
    logic w_advance;
    logic w_take;

    assign w_req.mode           = i_mode;
    assign w_req.request_type   = i_request_type;
    assign w_req.request_code   = i_request_code;
    assign w_req.request_value  = i_request_value;
    assign w_req.request_index  = i_request_index;
    assign w_req.request_length = i_request_length;

    // The result register frees up when empty or when its word is taken.
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_advance   = r_in_valid && w_out_ready;
    assign o_stall     = r_in_valid && !w_out_ready;
    assign w_take      = i_valid && !o_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        if (w_out_ready) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= w_req;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    usbreq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    usbreq_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_advance),
        .i_next   (w_dev_next),
        .o_dev    (w_dev)
    );

    usbreq_decode u_decode (
        .i_req      (r_req),
        .i_dev      (w_dev),
        .i_cfg      (w_cfg),
        .o_res      (w_res),
        .o_dev_next (w_dev_next)
    );

    assign o_valid             = r_out_valid;
    assign o_action            = r_res.action;
    assign o_reply_data        = r_res.reply_data;
    assign o_reply_length      = r_res.reply_length;
    assign o_descriptor_select = r_res.descriptor_select;
    assign o_address_load      = r_res.address_load;
    assign o_new_address       = r_res.new_address;
    assign o_config_load       = r_res.config_load;
    assign o_config_number     = r_res.config_number;
    assign o_is_configured     = r_res.is_configured;

    `ASSERT_IMPL(a_stall_needs_word, i_clk, i_rst_n, o_stall, r_in_valid, "stall without a held word")
    `ASSERT_NEXT(a_bus_reset_reply, i_clk, i_rst_n, w_advance && r_req.mode, o_valid && o_action == usbreq_pkg::ACT_NONE && !o_is_configured, "bus reset gave a reply or left the device configured")
    `ASSERT_IMPL(a_cfg_load_configured, i_clk, i_rst_n, o_valid && o_config_load, o_is_configured && o_config_number != 8'd0, "configuration load without configured state")
    `ASSERT_IMPL(a_addr_load_zlp, i_clk, i_rst_n, o_valid && o_address_load, o_action == usbreq_pkg::ACT_ZLP, "address load without status reply")
    `ASSERT_IMPL(a_configured_has_cfg, i_clk, i_rst_n, w_dev.dev_state == usbreq_pkg::ST_CONFIGURED, w_dev.active_config != 8'd0, "configured state with configuration zero")

endmodule
